// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while reset is low.
`define CAU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define CAU_ASSERT(lbl, prop, msg) `CAU_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== src/cau_pkg.sv =====
package cau_pkg;

    // Operand format; FRAC_BITS must stay below DATA_WIDTH
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PORT_W     = 32;
    localparam int KIND_W     = 3;

    localparam int PW         = 2 * DATA_WIDTH;
    localparam int NW         = PW + 1;
    localparam int SHIFT_K    = DATA_WIDTH - FRAC_BITS;
    localparam int XW         = PW + FRAC_BITS;
    localparam int DIV_STAGES = DATA_WIDTH;

    // Queue depth must be a power of two
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [NW-1:0]         t_wide;

    localparam t_word VMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam t_word VMIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic signed [PORT_W-1:0] PORT_MAX = PORT_W'(VMAX);
    localparam logic signed [PORT_W-1:0] PORT_MIN = PORT_W'(VMIN);

    typedef enum logic [KIND_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_NEG  = 3'd5
    } t_op;

    typedef struct packed {
        t_op   op;
        t_word a_re;
        t_word a_im;
        t_word b_re;
        t_word b_im;
        t_word res_re;
        t_word res_im;
        logic  eq;
        logic  dz;
        logic  ov;
    } t_item;

    typedef struct packed {
        t_word res_re;
        t_word res_im;
        logic  is_div;
        logic  eq;
        logic  dz;
        logic  ov;
    } t_slot;

    typedef struct packed {
        t_word val;
        logic  ov;
    } t_sat;

    function automatic t_wide sext_word(input t_word w);
        return t_wide'(w);
    endfunction

    function automatic t_sat sat_wide(input t_wide v);
        t_sat s;
        if (v > t_wide'(VMAX)) begin
            s.val = VMAX;
            s.ov  = 1'b1;
        end else if (v < t_wide'(VMIN)) begin
            s.val = VMIN;
            s.ov  = 1'b1;
        end else begin
            s.val = v[DATA_WIDTH-1:0];
            s.ov  = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== src/cau_front.sv =====
module cau_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cau_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_a_re,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_a_im,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_b_re,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_b_im,
    input  logic                                i_full,
    output logic                                o_valid,
    output cau_pkg::t_item                      o_item
);
    import cau_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept, push;

    assign push    = r_valid && !i_full;
    assign busy    = r_valid && i_full;
    assign accept  = start && !busy;
    assign n_valid = accept || (r_valid && !push);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Decode the transaction and finish the one-step operations here
    always_comb begin
        t_sat s_re;
        t_sat s_im;
        n_item.op     = t_op'(i_kind);
        n_item.a_re   = i_a_re[DATA_WIDTH-1:0];
        n_item.a_im   = i_a_im[DATA_WIDTH-1:0];
        n_item.b_re   = i_b_re[DATA_WIDTH-1:0];
        n_item.b_im   = i_b_im[DATA_WIDTH-1:0];
        n_item.eq     = (n_item.a_re == n_item.b_re) && (n_item.a_im == n_item.b_im);
        n_item.dz     = (n_item.op == OP_DIV) && (n_item.b_re == '0) && (n_item.b_im == '0);
        s_re.val      = n_item.a_re;
        s_re.ov       = 1'b0;
        s_im.val      = n_item.a_im;
        s_im.ov       = 1'b0;
        case (n_item.op)
            OP_ADD: begin
                s_re = sat_wide(sext_word(n_item.a_re) + sext_word(n_item.b_re));
                s_im = sat_wide(sext_word(n_item.a_im) + sext_word(n_item.b_im));
            end
            OP_SUB: begin
                s_re = sat_wide(sext_word(n_item.a_re) - sext_word(n_item.b_re));
                s_im = sat_wide(sext_word(n_item.a_im) - sext_word(n_item.b_im));
            end
            OP_CONJ: begin
                s_im = sat_wide(-sext_word(n_item.a_im));
            end
            OP_NEG: begin
                s_re = sat_wide(-sext_word(n_item.a_re));
                s_im = sat_wide(-sext_word(n_item.a_im));
            end
            default: begin
            end
        endcase
        n_item.res_re = s_re.val;
        n_item.res_im = s_im.val;
        n_item.ov     = s_re.ov | s_im.ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/cau_fifo.sv =====
module cau_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cau_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cau_pkg::t_item o_item
);
    import cau_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               push, pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + FIFO_AW'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + FIFO_CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/cau_div.sv =====
module cau_div (
    input  logic                            i_clk,
    input  logic [cau_pkg::PW-1:0]          i_mag,
    input  logic                            i_neg,
    input  logic [cau_pkg::PW-1:0]          i_d,
    output logic [cau_pkg::DATA_WIDTH-1:0]  o_q,
    output logic                            o_neg,
    output logic                            o_big
);
    import cau_pkg::*;

    logic [PW-1:0]         r_rem [DIV_STAGES];
    logic [DATA_WIDTH-1:0] r_lo  [DIV_STAGES];
    logic [PW-1:0]         r_dd  [DIV_STAGES];
    logic [DATA_WIDTH-1:0] r_q   [DIV_STAGES + 1];
    logic                  r_ng  [DIV_STAGES + 1];
    logic                  r_bg  [DIV_STAGES + 1];
    logic [PW-1:0]         head;

    // High part of the scaled dividend; at or above d the quotient cannot fit
    assign head = PW'(i_mag >> SHIFT_K);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= head;
        r_lo[0]  <= DATA_WIDTH'(XW'(i_mag) << FRAC_BITS);
        r_dd[0]  <= i_d;
        r_q[0]   <= '0;
        r_ng[0]  <= i_neg;
        r_bg[0]  <= (head >= i_d);
    end

    // One restoring step per stage: shift in a dividend bit, subtract if it fits
    for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_step
        logic [PW:0] trial;
        logic        fits;
        assign trial = {r_rem[i-1], r_lo[i-1][DATA_WIDTH-1]};
        assign fits  = (trial >= {1'b0, r_dd[i-1]});

        always_ff @(posedge i_clk) begin
            r_q[i]  <= {r_q[i-1][DATA_WIDTH-2:0], fits};
            r_ng[i] <= r_ng[i-1];
            r_bg[i] <= r_bg[i-1];
        end

        if (i < DIV_STAGES) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[i] <= fits ? PW'(trial - {1'b0, r_dd[i-1]}) : trial[PW-1:0];
                r_lo[i]  <= {r_lo[i-1][DATA_WIDTH-2:0], 1'b0};
                r_dd[i]  <= r_dd[i-1];
            end
        end
    end

    assign o_q   = r_q[DIV_STAGES];
    assign o_neg = r_ng[DIV_STAGES];
    assign o_big = r_bg[DIV_STAGES];

endmodule

// ===== src/cau_back.sv =====
module cau_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  cau_pkg::t_item          i_item,
    output logic                    o_valid,
    output cau_pkg::t_slot          o_slot
);
    import cau_pkg::*;

    logic                  r_v1, r_v2;
    t_item                 r_it1, r_it2;
    logic signed [PW-1:0]  r_prr, r_pii, r_pir, r_pri, r_sr, r_si;
    t_wide                 r_sum_re, r_sum_im;
    logic [PW-1:0]         r_d;
    t_slot                 slot3;
    logic                  neg_re, neg_im;
    logic [PW-1:0]         mag_re, mag_im;
    logic                  r_sv [DIV_STAGES + 1];
    t_slot                 r_side [DIV_STAGES + 1];
    logic [DATA_WIDTH-1:0] q_re, q_im;
    logic                  qn_re, qn_im, qb_re, qb_im;
    logic                  r_ov_v;
    t_slot                 r_out, n_out;

    function automatic t_sat div_sat(input logic [DATA_WIDTH-1:0] q, input logic neg,
                                     input logic big);
        t_sat s;
        s.ov  = 1'b0;
        s.val = neg ? -$signed(q) : $signed(q);
        if (!neg && (big || q[DATA_WIDTH-1])) begin
            s.val = VMAX;
            s.ov  = 1'b1;
        end else if (neg && (big || (q[DATA_WIDTH-1] && (q[DATA_WIDTH-2:0] != '0)))) begin
            s.val = VMIN;
            s.ov  = 1'b1;
        end
        return s;
    endfunction

    // Stage 1: all cross products and the squares of B
    always_ff @(posedge i_clk) begin
        r_it1 <= i_item;
        r_prr <= i_item.a_re * i_item.b_re;
        r_pii <= i_item.a_im * i_item.b_im;
        r_pir <= i_item.a_im * i_item.b_re;
        r_pri <= i_item.a_re * i_item.b_im;
        r_sr  <= i_item.b_re * i_item.b_re;
        r_si  <= i_item.b_im * i_item.b_im;
    end

    // Stage 2: product sums and the divisor
    always_ff @(posedge i_clk) begin
        r_it2 <= r_it1;
        if (r_it1.op == OP_MUL) begin
            r_sum_re <= t_wide'(r_prr) - t_wide'(r_pii);
            r_sum_im <= t_wide'(r_pir) + t_wide'(r_pri);
        end else begin
            r_sum_re <= t_wide'(r_prr) + t_wide'(r_pii);
            r_sum_im <= t_wide'(r_pir) - t_wide'(r_pri);
        end
        r_d <= $unsigned(r_sr) + $unsigned(r_si);
    end

    // Stage 3: finish multiply, hand magnitudes to the dividers
    always_comb begin
        t_sat m_re;
        t_sat m_im;
        m_re          = sat_wide(r_sum_re >>> FRAC_BITS);
        m_im          = sat_wide(r_sum_im >>> FRAC_BITS);
        slot3.res_re  = r_it2.res_re;
        slot3.res_im  = r_it2.res_im;
        slot3.ov      = r_it2.ov;
        slot3.eq      = r_it2.eq;
        slot3.dz      = r_it2.dz;
        slot3.is_div  = (r_it2.op == OP_DIV) && !r_it2.dz;
        if (r_it2.op == OP_MUL) begin
            slot3.res_re = m_re.val;
            slot3.res_im = m_im.val;
            slot3.ov     = m_re.ov | m_im.ov;
        end
    end

    assign neg_re = r_sum_re[NW-1];
    assign neg_im = r_sum_im[NW-1];
    assign mag_re = PW'(neg_re ? -r_sum_re : r_sum_re);
    assign mag_im = PW'(neg_im ? -r_sum_im : r_sum_im);

    cau_div u_div_re (
        .i_clk (i_clk),
        .i_mag (mag_re),
        .i_neg (neg_re),
        .i_d   (r_d),
        .o_q   (q_re),
        .o_neg (qn_re),
        .o_big (qb_re)
    );

    cau_div u_div_im (
        .i_clk (i_clk),
        .i_mag (mag_im),
        .i_neg (neg_im),
        .i_d   (r_d),
        .o_q   (q_im),
        .o_neg (qn_im),
        .o_big (qb_im)
    );

    // Side band rides alongside the divider stages
    always_ff @(posedge i_clk) begin
        r_side[0] <= slot3;
    end

    for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            r_side[i] <= r_side[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i] <= 1'b0;
            end else begin
                r_sv[i] <= r_sv[i-1];
            end
        end
    end

    always_comb begin
        t_sat d_re;
        t_sat d_im;
        d_re  = div_sat(q_re, qn_re, qb_re);
        d_im  = div_sat(q_im, qn_im, qb_im);
        n_out = r_side[DIV_STAGES];
        if (r_side[DIV_STAGES].is_div) begin
            n_out.res_re = d_re.val;
            n_out.res_im = d_im.val;
            n_out.ov     = d_re.ov | d_im.ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_sv[0] <= 1'b0;
            r_ov_v  <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_sv[0] <= r_v2;
            r_ov_v  <= r_sv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_ov_v;
    assign o_slot  = r_out;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide,
// conjugate of A and negate of A (kind codes 0 to 5; codes 6 and 7 return A).
// A transaction is accepted on a rising edge with start high and busy low.
// The unit takes one transaction every cycle and busy stays low in normal use,
// because the execution pipeline never stalls. Each result appears on the o_res
// ports for exactly one cycle with o_done high, in acceptance order, and is taken at
// the edge that ends that cycle; the receiver cannot hold it off, so capture it
// in that cycle. The divider produces one restoring quotient bit per pipeline
// stage, DATA_WIDTH stages, and every operation travels the same path so
// results never reorder. Result parts that do not fit saturate and raise
// o_overflow. Division by zero returns A with o_divide_by_zero set and
// o_overflow clear. o_operands_equal compares A and B for every kind. Multiply
// rounds toward minus infinity, divide truncates toward zero.
`include "assert_macros.svh"

module complex_arithmetic_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cau_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_a_re,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_a_im,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_b_re,
    input  logic signed [cau_pkg::PORT_W-1:0]   i_b_im,
    output logic                                o_done,
    output logic signed [cau_pkg::PORT_W-1:0]   o_res_re,
    output logic signed [cau_pkg::PORT_W-1:0]   o_res_im,
    output logic                                o_operands_equal,
    output logic                                o_divide_by_zero,
    output logic                                o_overflow
);
    import cau_pkg::*;

    logic  f_valid, q_full, q_valid;
    t_item f_item, q_item;
    t_slot b_slot;
    logic  sat_part;

    // Front end: accept and decode each transaction
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .i_full  (q_full),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    // Short queue decouples decode from execution
    cau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back end: multiply and divide pipeline, drains the queue every cycle
    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_valid (o_done),
        .o_slot  (b_slot)
    );

    // Sign-extend results to the port width
    assign o_res_re         = PORT_W'(b_slot.res_re);
    assign o_res_im         = PORT_W'(b_slot.res_im);
    assign o_operands_equal = b_slot.eq;
    assign o_divide_by_zero = b_slot.dz;
    assign o_overflow       = b_slot.ov;

    // At least one result part sits on a saturation limit
    assign sat_part = (o_res_re == PORT_MAX) || (o_res_re == PORT_MIN) ||
                      (o_res_im == PORT_MAX) || (o_res_im == PORT_MIN);

    `CAU_ASSERT(a_never_busy, !busy, "queue backed up although the pipeline drains it")
    `CAU_ASSERT(a_dz_no_ov, (o_done && o_divide_by_zero) |-> !o_overflow, "dz with overflow")
    `CAU_ASSERT(a_ov_saturated, (o_done && o_overflow) |-> sat_part, "overflow not saturated")

endmodule

// ===== dv/tb_complex_arithmetic_unit.sv =====
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    typedef logic signed [31:0]  t_q16;
    typedef logic signed [127:0] t_big;

    // One operation as presented on the request ports
    typedef struct {
        logic [2:0] kind;
        t_q16       a_re;
        t_q16       a_im;
        t_q16       b_re;
        t_q16       b_im;
    } t_request;

    // One predicted answer as seen on the result ports
    typedef struct {
        t_q16 re;
        t_q16 im;
        logic eq;
        logic dz;
        logic ov;
    } t_answer;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] i_kind = '0;
    t_q16       i_a_re = '0;
    t_q16       i_a_im = '0;
    t_q16       i_b_re = '0;
    t_q16       i_b_im = '0;
    logic       o_done;
    t_q16       o_res_re;
    t_q16       o_res_im;
    logic       o_operands_equal;
    logic       o_divide_by_zero;
    logic       o_overflow;

    t_request pending_ops[$];
    t_answer  awaited_answers[$];
    int       errors = 0;
    int       answers_checked = 0;
    int       gap_left = 0;
    int       idle_cycles = 0;
    int       ops_per_kind[8];

    complex_arithmetic_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_a_re(i_a_re),
        .i_a_im(i_a_im),
        .i_b_re(i_b_re),
        .i_b_im(i_b_im),
        .o_done(o_done),
        .o_res_re(o_res_re),
        .o_res_im(o_res_im),
        .o_operands_equal(o_operands_equal),
        .o_divide_by_zero(o_divide_by_zero),
        .o_overflow(o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Clamp a wide value to the signed 32-bit range and note any clipping
    function automatic t_q16 clip32(input t_big v, inout logic ov);
        if (v > t_big'(32'sh7fff_ffff)) begin
            ov = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -t_big'(64'sh8000_0000)) begin
            ov = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Compute the expected complex result and flags for one request
    function automatic t_answer complex_result(input t_request r);
        t_answer ans;
        t_big    ar, ai, br, bi, den;
        logic    ov;
        ar = r.a_re;
        ai = r.a_im;
        br = r.b_re;
        bi = r.b_im;
        ov = 1'b0;
        ans.re = r.a_re;
        ans.im = r.a_im;
        ans.dz = 1'b0;
        ans.eq = (r.a_re == r.b_re) && (r.a_im == r.b_im);
        case (r.kind)
            OP_ADD: begin
                ans.re = clip32(ar + br, ov);
                ans.im = clip32(ai + bi, ov);
            end
            OP_SUB: begin
                ans.re = clip32(ar - br, ov);
                ans.im = clip32(ai - bi, ov);
            end
            OP_MUL: begin
                // arithmetic shift floors, matching round toward minus infinity
                ans.re = clip32((ar * br - ai * bi) >>> FRAC_BITS, ov);
                ans.im = clip32((ai * br + ar * bi) >>> FRAC_BITS, ov);
            end
            OP_DIV: begin
                if (br == 0 && bi == 0) begin
                    ans.dz = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    den = br * br + bi * bi;
                    ans.re = clip32(((ar * br + ai * bi) <<< FRAC_BITS) / den, ov);
                    ans.im = clip32(((ai * br - ar * bi) <<< FRAC_BITS) / den, ov);
                end
            end
            OP_CONJ: ans.im = clip32(-ai, ov);
            OP_NEG: begin
                ans.re = clip32(-ar, ov);
                ans.im = clip32(-ai, ov);
            end
            default: ;
        endcase
        ans.ov = ov;
        return ans;
    endfunction

    // Pick an operand: mostly extremes and small Q16.16 values, some fully random
    function automatic t_q16 pick_part();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return t_q16'($urandom_range(0, 4)) - 2;
            3: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
            4, 5: return t_q16'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            6: return t_q16'($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            default: return t_q16'($urandom());
        endcase
    endfunction

    function automatic t_request make_request(input logic [2:0] kind, input t_q16 ar,
                                              input t_q16 ai, input t_q16 br, input t_q16 bi);
        t_request r;
        r.kind = kind;
        r.a_re = ar;
        r.a_im = ai;
        r.b_re = br;
        r.b_im = bi;
        return r;
    endfunction

    // Idle length between transactions: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: account for the accepted transaction, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_answers.push_back(complex_result(
                    make_request(i_kind, i_a_re, i_a_im, i_b_re, i_b_im)));
                ops_per_kind[i_kind]++;
            end
            // hold the request while the block reports busy
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    i_kind <= pending_ops[0].kind;
                    i_a_re <= pending_ops[0].a_re;
                    i_a_im <= pending_ops[0].a_im;
                    i_b_re <= pending_ops[0].b_re;
                    i_b_im <= pending_ops[0].b_im;
                    void'(pending_ops.pop_front());
                    start <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results last one cycle, so compare every strobe against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (awaited_answers.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h", $realtime, o_res_re, o_res_im);
                errors++;
            end else begin
                if (o_res_re !== awaited_answers[0].re) begin
                    $display("%0t: res_re expected %h actual %h", $realtime,
                             awaited_answers[0].re, o_res_re);
                    errors++;
                end
                if (o_res_im !== awaited_answers[0].im) begin
                    $display("%0t: res_im expected %h actual %h", $realtime,
                             awaited_answers[0].im, o_res_im);
                    errors++;
                end
                if (o_operands_equal !== awaited_answers[0].eq) begin
                    $display("%0t: operands_equal expected %b actual %b", $realtime,
                             awaited_answers[0].eq, o_operands_equal);
                    errors++;
                end
                if (o_divide_by_zero !== awaited_answers[0].dz) begin
                    $display("%0t: divide_by_zero expected %b actual %b", $realtime,
                             awaited_answers[0].dz, o_divide_by_zero);
                    errors++;
                end
                if (o_overflow !== awaited_answers[0].ov) begin
                    $display("%0t: overflow expected %b actual %b", $realtime,
                             awaited_answers[0].ov, o_overflow);
                    errors++;
                end
                void'(awaited_answers.pop_front());
                answers_checked++;
            end
        end
    end

    // Watchdog: drop the run when neither side moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        t_q16 ar, ai, br, bi;
        logic [2:0] kind;
        // Directed: extremes, every operation, the special cases
        pending_ops.push_back(make_request(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000,
                                           32'sh0000_0001, -32'sh0000_0001));
        pending_ops.push_back(make_request(OP_ADD, 32'sh0001_0000, 32'sh0002_0000,
                                           32'sh0003_0000, -32'sh0001_0000));
        pending_ops.push_back(make_request(OP_SUB, 32'sh8000_0000, 32'sh7fff_ffff,
                                           32'sh0000_0001, -32'sh0000_0001));
        pending_ops.push_back(make_request(OP_SUB, 32'sh1234_5678, -32'sh0000_8000,
                                           32'sh1234_5678, -32'sh0000_8000));
        pending_ops.push_back(make_request(OP_MUL, 32'sh0001_8000, -32'sh0000_8000,
                                           32'sh0002_0000, 32'sh0000_4000));
        pending_ops.push_back(make_request(OP_MUL, 32'sh8000_0000, 32'sh8000_0000,
                                           32'sh8000_0000, 32'sh8000_0000));
        pending_ops.push_back(make_request(OP_MUL, 32'sh7fff_ffff, 32'sh8000_0000,
                                           32'sh7fff_ffff, 32'sh7fff_ffff));
        pending_ops.push_back(make_request(OP_MUL, -32'sh0000_0001, 32'sh0000_0001,
                                           32'sh0000_0001, 32'sh0000_0001));
        pending_ops.push_back(make_request(OP_DIV, 32'sh0003_0000, 32'sh0004_0000,
                                           32'sh0001_0000, 32'sh0002_0000));
        pending_ops.push_back(make_request(OP_DIV, 32'sh5555_0000, -32'sh1234_0000,
                                           32'sh0000_0000, 32'sh0000_0000));
        pending_ops.push_back(make_request(OP_DIV, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                           32'sh0000_0001, 32'sh0000_0000));
        pending_ops.push_back(make_request(OP_DIV, 32'sh8000_0000, 32'sh8000_0000,
                                           32'sh8000_0000, 32'sh8000_0000));
        pending_ops.push_back(make_request(OP_DIV, -32'sh0000_0007, 32'sh0000_0003,
                                           32'sh7fff_ffff, 32'sh8000_0000));
        pending_ops.push_back(make_request(OP_CONJ, 32'sh0001_0000, 32'sh8000_0000,
                                           32'sh0000_0000, 32'sh0000_0000));
        pending_ops.push_back(make_request(OP_CONJ, 32'sh8000_0000, 32'sh7fff_ffff,
                                           32'sh8000_0000, 32'sh7fff_ffff));
        pending_ops.push_back(make_request(OP_NEG, 32'sh8000_0000, 32'sh8000_0000,
                                           32'sh0000_0001, 32'sh0000_0001));
        pending_ops.push_back(make_request(OP_NEG, 32'sh7fff_ffff, -32'sh0000_0001,
                                           32'sh0000_0000, 32'sh0000_0000));
        pending_ops.push_back(make_request(3'd6, 32'sh7fff_ffff, 32'sh8000_0000,
                                           32'sh0000_0000, 32'sh0000_0000));
        pending_ops.push_back(make_request(3'd7, -32'sh0000_0001, 32'sh0000_0000,
                                           -32'sh0000_0001, 32'sh0000_0000));

        // Random: mostly valid operations, with B zero or equal to A now and then
        repeat (900) begin
            kind = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            ar = pick_part();
            ai = pick_part();
            br = pick_part();
            bi = pick_part();
            case ($urandom_range(0, 11))
                0: begin
                    br = ar;
                    bi = ai;
                end
                1: begin
                    br = '0;
                    bi = '0;
                end
                2: bi = '0;
                default: ;
            endcase
            pending_ops.push_back(make_request(kind, ar, ai, br, bi));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the driver to drain, then for every prediction to be matched
        while (pending_ops.size() > 0 || start) @(posedge i_clk);
        while (awaited_answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered add %0d sub %0d mul %0d div %0d conj %0d neg %0d other %0d",
                 ops_per_kind[0], ops_per_kind[1], ops_per_kind[2], ops_per_kind[3],
                 ops_per_kind[4], ops_per_kind[5], ops_per_kind[6] + ops_per_kind[7]);
        $display("%0d results compared, %0d mismatches", answers_checked, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== complex_arithmetic_unit.f =====
+incdir+src
src/cau_pkg.sv
src/cau_front.sv
src/cau_fifo.sv
src/cau_div.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
dv/tb_complex_arithmetic_unit.sv
